@@ src/qbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qbd_pkg
// shared constants, types and helpers of the quantized box delta decoder
// ----------------------------------------------------------------------------
package qbd_pkg;

  localparam int NUM_STAGES = 8;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;

  localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef enum logic [2:0] {
    REG_BOX_GAIN     = 3'd0,
    REG_DELTA_GAINS  = 3'd1,
    REG_SIZE_CLIP    = 3'd2,
    REG_IMAGE_LIMITS = 3'd3,
    REG_OUT_GAIN     = 3'd4,
    REG_ZERO_POINTS  = 3'd5,
    REG_CORRECTED    = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // 2^(i/16) in q16.16
  function automatic logic [17:0] pow2_lut(input logic [4:0] idx);
    logic [17:0] r;
    case (idx)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd68438;
      5'd2:    r = 18'd71468;
      5'd3:    r = 18'd74632;
      5'd4:    r = 18'd77936;
      5'd5:    r = 18'd81386;
      5'd6:    r = 18'd84990;
      5'd7:    r = 18'd88752;
      5'd8:    r = 18'd92682;
      5'd9:    r = 18'd96785;
      5'd10:   r = 18'd101070;
      5'd11:   r = 18'd105545;
      5'd12:   r = 18'd110218;
      5'd13:   r = 18'd115098;
      5'd14:   r = 18'd120194;
      5'd15:   r = 18'd125515;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/qbd_dequant.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qbd_dequant
// one lane: dequantizes a corner to q16.16 and a delta to scaled q16.16
// ----------------------------------------------------------------------------
module qbd_dequant import qbd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        corner,
  input  wire logic [7:0]         delta,
  input  wire logic [15:0]        box_zero,
  input  wire logic [7:0]         delta_zero,
  input  wire logic [23:0]        box_gain,
  input  wire logic [15:0]        delta_gain,
  output logic signed [31:0]      corner_q,
  output logic signed [29:0]      delta_q
);

  logic signed [16:0] corner_off;
  logic signed [41:0] corner_prod;
  logic signed [8:0]  delta_off;
  logic signed [25:0] delta_prod;

  assign corner_off  = $signed({1'b0, corner}) - $signed({1'b0, box_zero});
  assign corner_prod = 42'(corner_off) * 42'($signed({1'b0, box_gain}));
  assign delta_off   = $signed({1'b0, delta}) - $signed({1'b0, delta_zero});
  assign delta_prod  = 26'(delta_off) * 26'($signed({1'b0, delta_gain}));

  always_ff @(posedge clk) begin
    if (en) begin
      corner_q <= sat32(64'(corner_prod));
      delta_q  <= 30'(delta_prod) <<< 4;
    end
  end

endmodule
`default_nettype wire

@@ src/qbd_axis.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qbd_axis
// one axis lane: size, center, exp of the size delta, predicted corners, clamp
// ----------------------------------------------------------------------------
module qbd_axis import qbd_pkg::*; (
  input  wire logic               clk,
  input  wire stage_en_t          en,
  input  wire logic signed [31:0] c_near,
  input  wire logic signed [31:0] c_far,
  input  wire logic signed [29:0] d_ctr,
  input  wire logic signed [29:0] d_size,
  input  wire logic signed [15:0] clip,
  input  wire logic [15:0]        limit,
  input  wire logic               corrected,
  output logic [31:0]             lo,
  output logic [31:0]             hi
);

  function automatic logic [31:0] clamp_lim(input logic signed [56:0] v,
                                            input logic [15:0] lim);
    logic signed [56:0] top;
    top = 57'($signed({1'b0, lim, 16'h0000}));
    if (v < 57'sd0) begin
      return 32'd0;
    end else if (v > top) begin
      return {lim, 16'h0000};
    end
    return v[31:0];
  endfunction

  // stage 2
  logic signed [33:0] size_sum;
  logic signed [31:0] size_w;
  logic signed [29:0] clip_q;
  logic signed [29:0] d_clip;
  logic signed [47:0] y_prod;
  logic signed [31:0] size2;
  logic signed [32:0] ctr2;
  logic signed [29:0] dctr2;
  logic signed [31:0] y2;

  assign size_sum = 34'(c_far) - 34'(c_near) + 34'sd65536;
  assign size_w   = sat32(64'(size_sum));
  assign clip_q   = 30'(clip) <<< 4;
  assign d_clip   = (d_size > clip_q) ? clip_q : d_size;
  assign y_prod   = 48'(d_clip) * 48'(LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      size2 <= size_w;
      ctr2  <= 33'(c_near) + 33'(size_w >>> 1);
      dctr2 <= d_ctr;
      y2    <= 32'(y_prod >>> 16);
    end
  end

  // stage 3
  logic [17:0]        tab_lo;
  logic [17:0]        tab_hi;
  logic [29:0]        interp;
  logic [17:0]        mant3;
  logic signed [15:0] ip3;
  logic signed [61:0] dwp3;
  logic signed [31:0] size3;
  logic signed [32:0] ctr3;

  assign tab_lo = pow2_lut({1'b0, y2[15:12]});
  assign tab_hi = pow2_lut(5'({1'b0, y2[15:12]}) + 5'd1);
  assign interp = 30'(tab_hi - tab_lo) * 30'(y2[11:0]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mant3 <= tab_lo + 18'(interp >> 12);
      ip3   <= 16'(y2 >>> 16);
      dwp3  <= 62'(dctr2) * 62'(size2);
      size3 <= size2;
      ctr3  <= ctr2;
    end
  end

  // stage 4
  logic [17:0]        emant_next;
  logic [4:0]         sh_next;
  logic [5:0]         rsh;
  logic [17:0]        emant4;
  logic [4:0]         sh4;
  logic signed [46:0] pctr4;
  logic signed [31:0] size4;

  assign rsh = 6'(-ip3);

  always_comb begin
    emant_next = mant3;
    sh_next    = 5'd0;
    if (!ip3[15]) begin
      sh_next = (ip3 > 16'sd20) ? 5'd20 : ip3[4:0];
    end else if (ip3 < -16'sd40) begin
      emant_next = 18'd0;
    end else begin
      emant_next = mant3 >> rsh;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      emant4 <= emant_next;
      sh4    <= sh_next;
      pctr4  <= 47'(ctr3) + 47'(dwp3 >>> 16);
      size4  <= size3;
    end
  end

  // stage 5
  logic signed [50:0] prod5;
  logic [4:0]         sh5;
  logic signed [46:0] pctr5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      prod5 <= 51'($signed({1'b0, emant4})) * 51'(size4);
      sh5   <= sh4;
      pctr5 <= pctr4;
    end
  end

  // stage 6
  logic signed [70:0] pw_wide;
  logic signed [54:0] pw;
  logic signed [54:0] half_w;
  logic signed [56:0] lo_raw;
  logic signed [56:0] hi_raw;

  assign pw_wide = 71'(prod5) <<< sh5;
  assign pw      = 55'(pw_wide >>> 16);
  assign half_w  = pw >>> 1;
  assign lo_raw  = 57'(pctr5) - 57'(half_w);
  assign hi_raw  = 57'(pctr5) + 57'(half_w) - (corrected ? 57'sd65536 : 57'sd0);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      lo <= clamp_lim(lo_raw, limit);
      hi <= clamp_lim(hi_raw, limit);
    end
  end

endmodule
`default_nettype wire

@@ src/qbd_quant.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qbd_quant
// one output lane: scale, round half away, add zero point, saturate
// ----------------------------------------------------------------------------
module qbd_quant import qbd_pkg::*; (
  input  wire logic        clk,
  input  wire stage_en_t   en,
  input  wire logic [31:0] coord,
  input  wire logic [23:0] out_gain,
  input  wire logic [15:0] out_zero,
  output logic [15:0]      q
);

  logic [55:0] prod;
  logic [24:0] rounded;
  logic [25:0] biased;

  assign rounded = 25'((prod + 56'h0000_0080_000000) >> 32);
  assign biased  = 26'(rounded) + 26'(out_zero);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      prod <= 56'(coord) * 56'(out_gain);
    end
    if (en[7]) begin
      q <= (biased > 26'd65535) ? 16'hffff : biased[15:0];
    end
  end

endmodule
`default_nettype wire

@@ src/quantized_bbox_delta_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quantized_bbox_delta_decode
// box delta decoder: dequantize, apply deltas through exp, clamp, requantize
// ----------------------------------------------------------------------------
// Eight-stage pipeline with four dequant lanes, two axis lanes (x and y) and
// four output lanes; one request is taken every cycle while the first stage can
// accept it. Each stage holds its request until the next stage frees,
// so a stalled output only backs up the pipeline as far as it is full. The
// configuration registers sit behind an APB-style port at byte address 8*i
// and must only be written while no request is in flight.
module quantized_bbox_delta_decode import qbd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [15:0]       box_left,
  input  wire logic [15:0]       box_top,
  input  wire logic [15:0]       box_right,
  input  wire logic [15:0]       box_bottom,
  input  wire logic [7:0]        shift_x,
  input  wire logic [7:0]        shift_y,
  input  wire logic [7:0]        log_width,
  input  wire logic [7:0]        log_height,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            pred_left,
  output logic [15:0]            pred_top,
  output logic [15:0]            pred_right,
  output logic [15:0]            pred_bottom
);

  logic [23:0] box_gain;
  logic [63:0] delta_gains;
  logic [15:0] size_clip;
  logic [31:0] image_limits;
  logic [23:0] out_gain;
  logic [39:0] zero_points;
  logic        corrected_coords;
  reg_idx_t    reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_gain         <= 24'd65536;
      delta_gains      <= 64'h1000_1000_1000_1000;
      size_clip        <= 16'd16937;
      image_limits     <= 32'hffff_ffff;
      out_gain         <= 24'd65536;
      zero_points      <= 40'd0;
      corrected_coords <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BOX_GAIN:     box_gain         <= pwdata[23:0];
        REG_DELTA_GAINS:  delta_gains      <= pwdata;
        REG_SIZE_CLIP:    size_clip        <= pwdata[15:0];
        REG_IMAGE_LIMITS: image_limits     <= pwdata[31:0];
        REG_OUT_GAIN:     out_gain         <= pwdata[23:0];
        REG_ZERO_POINTS:  zero_points      <= pwdata[39:0];
        REG_CORRECTED:    corrected_coords <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BOX_GAIN:     prdata = 64'(box_gain);
      REG_DELTA_GAINS:  prdata = delta_gains;
      REG_SIZE_CLIP:    prdata = 64'(size_clip);
      REG_IMAGE_LIMITS: prdata = 64'(image_limits);
      REG_OUT_GAIN:     prdata = 64'(out_gain);
      REG_ZERO_POINTS:  prdata = 64'(zero_points);
      REG_CORRECTED:    prdata = 64'(corrected_coords);
      default:          prdata = 64'd0;
    endcase
  end

  // pipeline control
  stage_en_t vld;
  stage_en_t en;

  always_comb begin
    en[NUM_STAGES-1] = ~vld[NUM_STAGES-1] | out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NUM_STAGES-1];

  // dequant lanes
  logic [15:0]        corner_in [4];
  logic [7:0]         delta_in  [4];
  logic signed [31:0] corner_q  [4];
  logic signed [29:0] delta_q   [4];

  assign corner_in[0] = box_left;
  assign corner_in[1] = box_top;
  assign corner_in[2] = box_right;
  assign corner_in[3] = box_bottom;
  assign delta_in[0]  = shift_x;
  assign delta_in[1]  = shift_y;
  assign delta_in[2]  = log_width;
  assign delta_in[3]  = log_height;

  for (genvar g = 0; g < 4; g++) begin : g_dq
    qbd_dequant u_dequant (
      .clk        (clk),
      .en         (en[0]),
      .corner     (corner_in[g]),
      .delta      (delta_in[g]),
      .box_zero   (zero_points[15:0]),
      .delta_zero (zero_points[23:16]),
      .box_gain   (box_gain),
      .delta_gain (delta_gains[16*g +: 16]),
      .corner_q   (corner_q[g]),
      .delta_q    (delta_q[g])
    );
  end

  // axis lanes
  logic [31:0] lo [2];
  logic [31:0] hi [2];

  for (genvar a = 0; a < 2; a++) begin : g_ax
    qbd_axis u_axis (
      .clk       (clk),
      .en        (en),
      .c_near    (corner_q[a]),
      .c_far     (corner_q[a+2]),
      .d_ctr     (delta_q[a]),
      .d_size    (delta_q[a+2]),
      .clip      ($signed(size_clip)),
      .limit     (image_limits[16*a +: 16]),
      .corrected (corrected_coords),
      .lo        (lo[a]),
      .hi        (hi[a])
    );
  end

  // output lanes
  logic [31:0] coord [4];
  logic [15:0] q     [4];

  assign coord[0] = lo[0];
  assign coord[1] = lo[1];
  assign coord[2] = hi[0];
  assign coord[3] = hi[1];

  for (genvar o = 0; o < 4; o++) begin : g_q
    qbd_quant u_quant (
      .clk      (clk),
      .en       (en),
      .coord    (coord[o]),
      .out_gain (out_gain),
      .out_zero (zero_points[39:24]),
      .q        (q[o])
    );
  end

  assign pred_left   = q[0];
  assign pred_top    = q[1];
  assign pred_right  = q[2];
  assign pred_bottom = q[3];

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !en[1] |=> vld[0])
    else $error("stalled first stage lost its request");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    vld == '0 |-> in_ready)
    else $error("empty pipeline refused a request");
`endif

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quantized box delta decoder: a local predictor
// computes each expected box, results are compared in order, config is
// written over apb between phases, both sides idle at random
// ----------------------------------------------------------------------------
module tb;
  import qbd_pkg::*;

  typedef struct packed {
    logic [15:0] l, t, r, b;
    logic [7:0]  sx, sy, lw, lh;
  } box_req_t;

  typedef struct packed {
    logic [15:0] l, t, r, b;
  } box_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] box_left = '0, box_top = '0, box_right = '0, box_bottom = '0;
  logic [7:0] shift_x = '0, shift_y = '0, log_width = '0, log_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] pred_left, pred_top, pred_right, pred_bottom;

  quantized_bbox_delta_decode dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [23:0] m_box_gain;
  logic [63:0] m_delta_gains;
  logic [15:0] m_size_clip;
  logic [31:0] m_image_limits;
  logic [23:0] m_out_gain;
  logic [39:0] m_zero_points;
  logic        m_corrected;

  box_res_t expected_boxes[$];
  int errors = 0;
  int idle_cycles = 0;
  bit tx_jitter = 1'b1;
  bit rx_jitter = 1'b1;
  bit rx_hold = 1'b0;

  localparam int TABLE_POW2[17] = '{65536, 68438, 71468, 74632, 77936, 81386,
    84990, 88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515,
    131072};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint exp_fixed(longint v);
    longint y, ip, f, fr, m;
    int idx;
    y = (v * 94548) >>> 16;
    ip = y >>> 16;
    f = y - ip * 65536;
    idx = int'((f >>> 12) & 15);
    fr = f & 12'hfff;
    m = TABLE_POW2[idx] + (((TABLE_POW2[idx + 1] - TABLE_POW2[idx]) * fr) >>> 12);
    if (ip >= 0) begin
      if (ip > 20) ip = 20;
      return m <<< ip;
    end
    if (ip < -40) return 0;
    return m >>> (-ip);
  endfunction

  function automatic logic [15:0] requantize(longint v, logic [15:0] lim);
    longint hi;
    logic [63:0] p, q;
    hi = longint'(lim) <<< 16;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    p = 64'(v) * 64'(m_out_gain);
    q = ((p + 64'h8000_0000) >> 32) + 64'(m_zero_points[39:24]);
    return (q > 64'd65535) ? 16'hffff : q[15:0];
  endfunction

  function automatic box_res_t decode_box(box_req_t r);
    longint c[4], d[4], clip, w, h, pcx, pcy, pw, ph, off;
    logic [15:0] qb[4];
    logic [7:0] qd[4];
    box_res_t o;
    qb = '{r.l, r.t, r.r, r.b};
    qd = '{r.sx, r.sy, r.lw, r.lh};
    for (int k = 0; k < 4; k++) begin
      c[k] = clamp32((longint'(qb[k]) - longint'(m_zero_points[15:0])) *
                     longint'(m_box_gain));
      d[k] = (longint'(qd[k]) - longint'(m_zero_points[23:16])) *
             longint'(m_delta_gains[16*k +: 16]) * 16;
    end
    clip = longint'($signed(m_size_clip)) * 16;
    if (d[2] > clip) d[2] = clip;
    if (d[3] > clip) d[3] = clip;
    w = clamp32(c[2] - c[0] + 65536);
    h = clamp32(c[3] - c[1] + 65536);
    pcx = c[0] + (w >>> 1) + ((d[0] * w) >>> 16);
    pcy = c[1] + (h >>> 1) + ((d[1] * h) >>> 16);
    pw = (exp_fixed(d[2]) * w) >>> 16;
    ph = (exp_fixed(d[3]) * h) >>> 16;
    off = m_corrected ? 65536 : 0;
    o.l = requantize(pcx - (pw >>> 1), m_image_limits[15:0]);
    o.t = requantize(pcy - (ph >>> 1), m_image_limits[31:16]);
    o.r = requantize(pcx + (pw >>> 1) - off, m_image_limits[15:0]);
    o.b = requantize(pcy + (ph >>> 1) - off, m_image_limits[31:16]);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(8 * int'(idx)); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BOX_GAIN:     m_box_gain = val[23:0];
      REG_DELTA_GAINS:  m_delta_gains = val;
      REG_SIZE_CLIP:    m_size_clip = val[15:0];
      REG_IMAGE_LIMITS: m_image_limits = val[31:0];
      REG_OUT_GAIN:     m_out_gain = val[23:0];
      REG_ZERO_POINTS:  m_zero_points = val[39:0];
      REG_CORRECTED:    m_corrected = val[0];
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_request(box_req_t r);
    while (tx_jitter && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {box_left, box_top, box_right, box_bottom} <= {r.l, r.t, r.r, r.b};
    {shift_x, shift_y, log_width, log_height} <= {r.sx, r.sy, r.lw, r.lh};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_boxes.push_back(decode_box(r));
    @(negedge clk);
  endtask

  function automatic box_req_t rand_request();
    box_req_t r;
    r = {$urandom, $urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      r.l = 16'($urandom_range(2000)); r.t = 16'($urandom_range(2000));
      r.r = r.l + 16'($urandom_range(1500)); r.b = r.t + 16'($urandom_range(1500));
    end
    return r;
  endfunction

  task automatic test_directed;
    box_req_t r;
    r = '0; send_request(r);
    r = '1; send_request(r);
    r = {16'd100, 16'd50, 16'd20, 16'd10, 8'd0, 8'd255, 8'd128, 8'd1};
    send_request(r);
    r = {16'd0, 16'd0, 16'hffff, 16'hffff, 8'h80, 8'h80, 8'h7f, 8'h7f};
    send_request(r);
    r = {16'hffff, 16'hffff, 16'd0, 16'd0, 8'hff, 8'h00, 8'h00, 8'hff};
    send_request(r);
    r = {16'd10, 16'd20, 16'd110, 16'd220, 8'd3, 8'd250, 8'd255, 8'd255};
    send_request(r);
    r = {16'd10, 16'd20, 16'd110, 16'd220, 8'd128, 8'd128, 8'd0, 8'd0};
    send_request(r);
    r = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 8'h55, 8'haa, 8'h55, 8'haa};
    send_request(r);
    drain();
  endtask

  task automatic test_config_extremes;
    box_req_t r;
    write_reg(REG_BOX_GAIN, 64'hffffff);
    write_reg(REG_DELTA_GAINS, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_SIZE_CLIP, 64'h8000);
    write_reg(REG_OUT_GAIN, 64'hffffff);
    write_reg(REG_ZERO_POINTS, 64'hff_ffff_ffff);
    write_reg(REG_CORRECTED, 64'd1);
    write_reg(REG_IMAGE_LIMITS, 64'h0100_0200);
    write_reg(REG_UNUSED, 64'h1234);
    for (int i = 0; i < 8; i++) send_request(rand_request());
    drain();
    write_reg(REG_BOX_GAIN, 64'd0);
    write_reg(REG_DELTA_GAINS, 64'd0);
    write_reg(REG_SIZE_CLIP, 64'h7fff);
    write_reg(REG_OUT_GAIN, 64'd0);
    write_reg(REG_ZERO_POINTS, 64'd0);
    write_reg(REG_IMAGE_LIMITS, 64'hffff_ffff);
    for (int i = 0; i < 4; i++) send_request(rand_request());
    drain();
    write_reg(REG_BOX_GAIN, 64'h10000);
    write_reg(REG_DELTA_GAINS, 64'h1000_1000_1000_1000);
    write_reg(REG_SIZE_CLIP, 64'hc000);
    write_reg(REG_OUT_GAIN, 64'h10000);
    r = {16'd10, 16'd20, 16'd110, 16'd220, 8'd0, 8'd0, 8'd0, 8'd0};
    send_request(r);
    drain();
  endtask

  task automatic test_random_settings;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_BOX_GAIN, 64'($urandom_range(20000, 200000)));
      write_reg(REG_DELTA_GAINS, {$urandom, $urandom} & 64'h3fff_3fff_3fff_3fff);
      write_reg(REG_SIZE_CLIP, 64'($urandom_range(0, 20000)));
      write_reg(REG_IMAGE_LIMITS, 64'({16'($urandom_range(100, 4000)),
                                       16'($urandom_range(100, 4000))}));
      write_reg(REG_OUT_GAIN, 64'($urandom_range(20000, 200000)));
      write_reg(REG_ZERO_POINTS, 64'({8'd0, 16'($urandom_range(200)),
                                      8'($urandom_range(100, 150)),
                                      16'($urandom_range(50))}));
      write_reg(REG_CORRECTED, 64'($urandom_range(1)));
      tx_jitter = (ph != 2);
      rx_jitter = (ph != 2);
      for (int i = 0; i < 60; i++) send_request(rand_request());
      drain();
    end
    tx_jitter = 1'b1; rx_jitter = 1'b1;
  endtask

  task automatic test_backpressure;
    rx_hold = 1'b1;
    fork
      begin
        repeat (60) @(negedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 70; i++) send_request(rand_request());
    join
    drain();
  endtask

  // result checking and receiver idling
  always @(negedge clk) begin
    out_ready <= !rx_hold && !(rx_jitter && $urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    box_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_boxes.size() == 0) begin
        report_mismatch("unexpected result", pred_left, 16'd0);
      end else begin
        e = expected_boxes.pop_front();
        if (pred_left !== e.l) report_mismatch("pred_left", pred_left, e.l);
        if (pred_top !== e.t) report_mismatch("pred_top", pred_top, e.t);
        if (pred_right !== e.r) report_mismatch("pred_right", pred_right, e.r);
        if (pred_bottom !== e.b) report_mismatch("pred_bottom", pred_bottom, e.b);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    m_box_gain = 24'h10000;
    m_delta_gains = 64'h1000_1000_1000_1000;
    m_size_clip = 16'd16937;
    m_image_limits = 32'hffff_ffff;
    m_out_gain = 24'h10000;
    m_zero_points = '0;
    m_corrected = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_random_settings();
    test_backpressure();
    drain();
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

@@ quantized_bbox_delta_decode.f @@
src/qbd_pkg.sv
src/qbd_dequant.sv
src/qbd_axis.sv
src/qbd_quant.sv
src/quantized_bbox_delta_decode.sv
dv/tb.sv
